FILE: sv/bgp_session_fsm_macros.svh
// Assertion macros for the BGP session controller checker.
// Depends on a clock named clock and a reset named reset in the using scope.
`ifndef BGP_SESSION_FSM_MACROS_SVH
`define BGP_SESSION_FSM_MACROS_SVH

// Check a property outside reset.
`define BSF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property at every edge, reset included.
`define BSF_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: sv/bsf_pkg.sv
// Types, codes and constants shared by the BGP session controller modules.
// No dependencies.
package bsf_pkg;

   localparam int unsigned HoldW  = 16;
   localparam int unsigned RetryW = 9;
   localparam int unsigned CsrDataW = 16;
   localparam int unsigned CsrIdxW  = 1;

   localparam logic [HoldW-1:0]  LocalHoldReset = 16'd90;
   localparam logic [RetryW-1:0] RetryReset     = 9'd30;
   localparam logic [RetryW-1:0] RetrySecsMax   = 9'd300;
   localparam logic [RetryW-1:0] DampIdleSecs   = 9'd5;

   typedef enum logic [2:0] {
      ST_IDLE         = 3'd0,
      ST_CONNECT      = 3'd1,
      ST_ACTIVE       = 3'd2,
      ST_OPEN_SENT    = 3'd3,
      ST_OPEN_CONFIRM = 3'd4,
      ST_ESTABLISHED  = 3'd5
   } state_type;

   typedef enum logic [4:0] {
      EV_MANUAL_STOP, EV_MANUAL_START, EV_AUTO_START, EV_MANUAL_START_PASSIVE,
      EV_AUTO_START_PASSIVE, EV_AUTO_START_DAMPED, EV_AUTO_START_DAMPED_PASSIVE,
      EV_IDLE_HOLD_EXPIRES, EV_RETRY_EXPIRES, EV_TCP_CONFIRMED, EV_TCP_CR_ACKED,
      EV_TCP_FAILS, EV_TCP_VALID, EV_TCP_CR_INVALID, EV_DELAY_OPEN, EV_BGP_OPEN,
      EV_HEADER_ERR, EV_OPEN_ERR, EV_AUTO_STOP, EV_HOLD_EXPIRES, EV_COLLISION_DUMP,
      EV_NOTIF_VER_ERR, EV_NOTIFICATION, EV_KEEPALIVE_MSG, EV_UPDATE_ERR,
      EV_UPDATE_MSG, EV_KEEPALIVE_EXPIRES, EV_ROUTE_REFRESH, EV_BFD_DOWN, EV_BFD_UP
   } event_type;

   typedef enum logic [3:0] {
      NTF_NONE, NTF_FSM_OPEN_SENT, NTF_ADMIN_SHUTDOWN, NTF_ADMIN_RESET,
      NTF_HOLD_EXPIRED, NTF_COLLISION, NTF_BAD_MSG_TYPE, NTF_FSM_OPEN_CONFIRM,
      NTF_UNSUP_PARAM, NTF_MALFORMED_ATTR, NTF_FSM_ESTABLISHED, NTF_BFD_DOWN
   } notify_type;

   typedef enum logic [1:0] {
      RETRY_NONE, RETRY_START, RETRY_STOP, RETRY_IDLE_HOLD
   } retry_cmd_type;

   typedef enum logic [1:0] {
      TMR_NONE, TMR_START, TMR_STOP, TMR_RESTART
   } timer_cmd_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_LOCAL_HOLD, CSR_RETRY_INTERVAL
   } csr_index_type;

   typedef struct packed {
      logic [4:0]       req_type;
      logic [HoldW-1:0] peer_hold_time;
      logic             collision_lost;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]        next_state;
      logic              send_open;
      logic              send_keepalive;
      logic [3:0]        notify_code;
      logic              close_conn;
      logic              open_tcp;
      logic              cancel_timers;
      logic [1:0]        retry_cmd;
      logic [RetryW-1:0] retry_secs;
      logic [1:0]        hold_cmd;
      logic [1:0]        keepalive_cmd;
      logic [HoldW-1:0]  hold_secs;
   } rsp_payload_type;

   typedef struct packed {
      logic             wr;
      logic [HoldW-1:0] value;
   } hold_upd_type;

endpackage

FILE: sv/bgp_session_fsm.sv
// BGP session controller (six-state session machine), top level.
// Depends on bsf_pkg, bsf_in_stage, bsf_decide and bsf_out_stage.
//
// Usage:
//   req_* carries one event request (event code, peer hold time,
//   collision-lost flag); rsp_* returns exactly one response per request:
//   next state, messages to send, transport actions and timer commands.
//   Both channels transfer on a rising edge with valid high and stall low.
//   csr_* writes the local hold time (index 0) and the connect retry
//   length (index 1); write only while no request is in flight.
//   A request in the input register moves into the result register
//   once that is free; its response shows from there. Throughput: one
//   request per cycle while rsp_stall is low; the state and hold time
//   in use update as each request moves from the input register into
//   the result register, so the next request sees them at once.
//   Reset (synchronous, active high) empties both registers, puts the
//   session in Idle with hold time 0 and restores 90 s / 30 s settings.
//   While the receiver stalls, the response holds; the input register
//   fills and then req_stall rises until the result register frees.
module bgp_session_fsm import bsf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_payload_type     req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_payload_type     rsp_data,
   input  logic                csr_wr_en,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   state_type         state_ff, state_in;
   logic [HoldW-1:0]  hold_ff;
   logic [HoldW-1:0]  local_hold_ff;
   logic [RetryW-1:0] retry_ff;
   logic              advance;
   logic              in_valid;
   req_payload_type   in_data;
   rsp_payload_type   dec_rsp;
   hold_upd_type      hold_upd;

   bsf_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .advance   (advance),
      .in_valid  (in_valid),
      .in_data   (in_data)
   );

   bsf_decide u_decide (
      .state          (state_ff),
      .hold_in_use    (hold_ff),
      .local_hold     (local_hold_ff),
      .retry_interval (retry_ff),
      .req            (in_data),
      .state_in       (state_in),
      .rsp            (dec_rsp),
      .hold_upd       (hold_upd)
   );

   bsf_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_data   (dec_rsp),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hold_ff  <= '0;
      end else if (advance) begin
         state_ff <= state_in;
         if (hold_upd.wr) begin
            hold_ff <= hold_upd.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_hold_ff <= LocalHoldReset;
         retry_ff      <= RetryReset;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_LOCAL_HOLD:     local_hold_ff <= csr_wdata[HoldW-1:0];
            CSR_RETRY_INTERVAL: retry_ff      <= csr_wdata[RetryW-1:0];
         endcase
      end
   end

endmodule

FILE: sv/bsf_in_stage.sv
// Input register of the BGP session controller: holds one request until
// the decision stage takes it. Depends on bsf_pkg.
module bsf_in_stage import bsf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   input  logic            advance,
   output logic            in_valid,
   output req_payload_type in_data
);

   logic            valid_ff, valid_in;
   req_payload_type data_ff;
   logic            take;

   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= req_data;
      end
   end

   assign in_valid = valid_ff;
   assign in_data  = data_ff;

endmodule

FILE: sv/bsf_decide.sv
// Session decision logic: next state, messages, transport actions and
// timer commands for one event. Depends on bsf_pkg.
module bsf_decide import bsf_pkg::*; (
   input  state_type         state,
   input  logic [HoldW-1:0]  hold_in_use,
   input  logic [HoldW-1:0]  local_hold,
   input  logic [RetryW-1:0] retry_interval,
   input  req_payload_type   req,
   output state_type         state_in,
   output rsp_payload_type   rsp,
   output hold_upd_type      hold_upd
);

   event_type         ev;
   logic              conn;
   logic              lost;
   logic [HoldW-1:0]  peer;
   logic [HoldW-1:0]  min_hold;
   logic [RetryW-1:0] retry_len;

   assign ev        = event_type'(req.req_type);
   assign conn      = (state == ST_CONNECT);
   assign lost      = req.collision_lost;
   assign peer      = req.peer_hold_time;
   assign min_hold  = (peer < local_hold) ? peer : local_hold;
   assign retry_len = (retry_interval > RetrySecsMax) ? RetrySecsMax : retry_interval;

   function automatic rsp_payload_type to_idle(rsp_payload_type r, notify_type code);
      rsp_payload_type o;
      o               = r;
      o.cancel_timers = 1'b1;
      o.close_conn    = 1'b1;
      o.notify_code   = code;
      o.retry_cmd     = RETRY_NONE;
      o.hold_cmd      = TMR_NONE;
      o.keepalive_cmd = TMR_NONE;
      return o;
   endfunction

   always_comb begin
      state_in = state;
      unique case (state)
         ST_CONNECT, ST_ACTIVE: begin
            unique case (ev)
               EV_RETRY_EXPIRES:                  state_in = ST_CONNECT;
               EV_TCP_CONFIRMED, EV_TCP_CR_ACKED: state_in = ST_OPEN_SENT;
               EV_TCP_FAILS:                      state_in = ST_ACTIVE;
               EV_TCP_VALID, EV_TCP_CR_INVALID:   state_in = conn ? state : ST_IDLE;
               EV_DELAY_OPEN, EV_BGP_OPEN:        state_in = conn ? ST_OPEN_CONFIRM : ST_IDLE;
               default:                           state_in = ST_IDLE;
            endcase
         end
         ST_OPEN_SENT: begin
            unique case (ev)
               EV_TCP_FAILS: state_in = ST_ACTIVE;
               EV_BGP_OPEN:  state_in = ST_OPEN_CONFIRM;
               default:      state_in = ST_IDLE;
            endcase
         end
         ST_OPEN_CONFIRM: begin
            unique case (ev)
               EV_KEEPALIVE_EXPIRES: state_in = ST_OPEN_CONFIRM;
               EV_BGP_OPEN:          state_in = lost ? ST_IDLE : ST_OPEN_CONFIRM;
               EV_KEEPALIVE_MSG:     state_in = ST_ESTABLISHED;
               default:              state_in = ST_IDLE;
            endcase
         end
         ST_ESTABLISHED: begin
            unique case (ev)
               EV_MANUAL_STOP, EV_AUTO_STOP, EV_HOLD_EXPIRES, EV_TCP_FAILS,
               EV_NOTIF_VER_ERR, EV_NOTIFICATION, EV_HEADER_ERR, EV_OPEN_ERR,
               EV_UPDATE_ERR, EV_BFD_DOWN:
                  state_in = ST_IDLE;
               EV_BGP_OPEN: state_in = lost ? ST_IDLE : ST_ESTABLISHED;
               default:     state_in = ST_ESTABLISHED;
            endcase
         end
         default: begin
            unique case (ev)
               EV_MANUAL_START, EV_AUTO_START, EV_IDLE_HOLD_EXPIRES:
                  state_in = ST_CONNECT;
               EV_MANUAL_START_PASSIVE, EV_AUTO_START_PASSIVE:
                  state_in = ST_ACTIVE;
               default: state_in = ST_IDLE;
            endcase
         end
      endcase
   end

   always_comb begin
      rsp            = '0;
      hold_upd       = '0;
      unique case (state)
         ST_CONNECT, ST_ACTIVE: begin
            unique case (ev)
               EV_MANUAL_STOP: begin
                  rsp.cancel_timers = 1'b1;
                  rsp.close_conn    = 1'b1;
               end
               EV_RETRY_EXPIRES: begin
                  rsp.close_conn = conn;
                  rsp.retry_cmd  = RETRY_START;
                  rsp.retry_secs = retry_len;
                  rsp.open_tcp   = 1'b1;
               end
               EV_TCP_CONFIRMED, EV_TCP_CR_ACKED: begin
                  rsp.retry_cmd = RETRY_STOP;
                  rsp.send_open = 1'b1;
               end
               EV_TCP_FAILS: begin
                  rsp.close_conn = 1'b1;
                  rsp.retry_cmd  = RETRY_START;
                  rsp.retry_secs = retry_len;
               end
               EV_TCP_VALID, EV_TCP_CR_INVALID: begin
                  if (!conn) begin
                     rsp = to_idle(rsp, NTF_FSM_OPEN_SENT);
                  end
               end
               EV_DELAY_OPEN, EV_BGP_OPEN: begin
                  if (!conn) begin
                     rsp = to_idle(rsp, NTF_FSM_OPEN_SENT);
                  end else begin
                     rsp.retry_cmd      = RETRY_STOP;
                     rsp.send_open      = 1'b1;
                     rsp.send_keepalive = 1'b1;
                     hold_upd.wr        = 1'b1;
                     hold_upd.value     = peer;
                     if (peer != '0) begin
                        rsp.keepalive_cmd = TMR_START;
                        rsp.hold_secs     = peer;
                     end
                  end
               end
               EV_AUTO_STOP: rsp = to_idle(rsp, NTF_NONE);
               default:      rsp = to_idle(rsp, NTF_FSM_OPEN_SENT);
            endcase
         end
         ST_OPEN_SENT: begin
            unique case (ev)
               EV_MANUAL_STOP:    rsp = to_idle(rsp, NTF_ADMIN_SHUTDOWN);
               EV_AUTO_STOP:      rsp = to_idle(rsp, NTF_ADMIN_RESET);
               EV_HOLD_EXPIRES:   rsp = to_idle(rsp, NTF_HOLD_EXPIRED);
               EV_TCP_FAILS: begin
                  rsp.hold_cmd   = TMR_STOP;
                  rsp.close_conn = 1'b1;
                  rsp.retry_cmd  = RETRY_START;
                  rsp.retry_secs = retry_len;
               end
               EV_BGP_OPEN: begin
                  hold_upd.wr        = 1'b1;
                  hold_upd.value     = min_hold;
                  rsp.retry_cmd      = RETRY_STOP;
                  rsp.send_keepalive = 1'b1;
                  if (min_hold != '0) begin
                     rsp.hold_cmd      = TMR_START;
                     rsp.keepalive_cmd = TMR_START;
                     rsp.hold_secs     = min_hold;
                  end else begin
                     rsp.hold_cmd      = TMR_STOP;
                     rsp.keepalive_cmd = TMR_STOP;
                  end
               end
               EV_COLLISION_DUMP: rsp = to_idle(rsp, NTF_COLLISION);
               EV_HEADER_ERR:     rsp = to_idle(rsp, NTF_BAD_MSG_TYPE);
               EV_OPEN_ERR, EV_NOTIF_VER_ERR, EV_NOTIFICATION:
                  rsp = to_idle(rsp, NTF_NONE);
               default:           rsp = to_idle(rsp, NTF_FSM_OPEN_SENT);
            endcase
         end
         ST_OPEN_CONFIRM: begin
            unique case (ev)
               EV_MANUAL_STOP:  rsp = to_idle(rsp, NTF_ADMIN_SHUTDOWN);
               EV_AUTO_STOP:    rsp = to_idle(rsp, NTF_ADMIN_RESET);
               EV_HOLD_EXPIRES: rsp = to_idle(rsp, NTF_HOLD_EXPIRED);
               EV_KEEPALIVE_EXPIRES: begin
                  rsp.send_keepalive = 1'b1;
                  rsp.keepalive_cmd  = TMR_RESTART;
                  rsp.hold_secs      = hold_in_use;
               end
               EV_TCP_FAILS, EV_NOTIF_VER_ERR, EV_NOTIFICATION:
                  rsp = to_idle(rsp, NTF_NONE);
               EV_BGP_OPEN: begin
                  if (lost) begin
                     rsp = to_idle(rsp, NTF_COLLISION);
                  end
               end
               EV_COLLISION_DUMP: rsp = to_idle(rsp, NTF_COLLISION);
               EV_HEADER_ERR:     rsp = to_idle(rsp, NTF_BAD_MSG_TYPE);
               EV_OPEN_ERR:       rsp = to_idle(rsp, NTF_UNSUP_PARAM);
               EV_KEEPALIVE_MSG: begin
                  if (hold_in_use != '0) begin
                     rsp.hold_cmd  = TMR_RESTART;
                     rsp.hold_secs = hold_in_use;
                  end
                  rsp.retry_cmd = RETRY_STOP;
               end
               EV_UPDATE_ERR: rsp = to_idle(rsp, NTF_MALFORMED_ATTR);
               default:       rsp = to_idle(rsp, NTF_FSM_OPEN_CONFIRM);
            endcase
         end
         ST_ESTABLISHED: begin
            unique case (ev)
               EV_MANUAL_STOP:  rsp = to_idle(rsp, NTF_ADMIN_SHUTDOWN);
               EV_AUTO_STOP:    rsp = to_idle(rsp, NTF_ADMIN_RESET);
               EV_HOLD_EXPIRES: rsp = to_idle(rsp, NTF_HOLD_EXPIRED);
               EV_KEEPALIVE_EXPIRES: begin
                  rsp.send_keepalive = 1'b1;
                  rsp.keepalive_cmd  = TMR_RESTART;
                  rsp.hold_secs      = hold_in_use;
               end
               EV_TCP_FAILS, EV_NOTIF_VER_ERR, EV_NOTIFICATION:
                  rsp = to_idle(rsp, NTF_NONE);
               EV_BGP_OPEN: begin
                  if (lost) begin
                     rsp = to_idle(rsp, NTF_COLLISION);
                  end
               end
               EV_HEADER_ERR: rsp = to_idle(rsp, NTF_BAD_MSG_TYPE);
               EV_OPEN_ERR:   rsp = to_idle(rsp, NTF_FSM_ESTABLISHED);
               EV_KEEPALIVE_MSG, EV_UPDATE_MSG: begin
                  if (hold_in_use != '0) begin
                     rsp.hold_cmd  = TMR_RESTART;
                     rsp.hold_secs = hold_in_use;
                  end
               end
               EV_UPDATE_ERR: rsp = to_idle(rsp, NTF_MALFORMED_ATTR);
               EV_BFD_DOWN:   rsp = to_idle(rsp, NTF_BFD_DOWN);
               default: begin
                  rsp.cancel_timers = 1'b0;
               end
            endcase
         end
         default: begin
            unique case (ev)
               EV_MANUAL_START, EV_AUTO_START, EV_IDLE_HOLD_EXPIRES: begin
                  rsp.retry_cmd  = RETRY_START;
                  rsp.retry_secs = retry_len;
                  rsp.open_tcp   = 1'b1;
               end
               EV_MANUAL_START_PASSIVE, EV_AUTO_START_PASSIVE: begin
                  rsp.retry_cmd  = RETRY_START;
                  rsp.retry_secs = retry_len;
               end
               EV_AUTO_START_DAMPED, EV_AUTO_START_DAMPED_PASSIVE: begin
                  rsp.retry_cmd  = RETRY_IDLE_HOLD;
                  rsp.retry_secs = DampIdleSecs;
               end
               default: begin
                  rsp.open_tcp = 1'b0;
               end
            endcase
         end
      endcase
      rsp.next_state = state_in;
   end

endmodule

FILE: sv/bsf_out_stage.sv
// Result register of the BGP session controller: holds one response
// until the receiver takes it. Depends on bsf_pkg.
module bsf_out_stage import bsf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  rsp_payload_type in_data,
   output logic            advance,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   logic            valid_ff, valid_in;
   rsp_payload_type data_ff;

   assign advance = in_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= in_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: sv/bsf_checker.sv
// Port-level checks for the BGP session controller, bound to the top level.
// Depends on bsf_pkg and bgp_session_fsm_macros.svh.
`include "bgp_session_fsm_macros.svh"

module bsf_checker import bsf_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_data
);

   `BSF_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled response changed")
   `BSF_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid && !req_stall, "pipeline not empty after reset")
   `BSF_ASSERT(a_cancel_idle, rsp_valid && rsp_data.cancel_timers |-> rsp_data.close_conn && (rsp_data.next_state == ST_IDLE), "timers cancelled outside a drop to idle")
   `BSF_ASSERT(a_retry_secs, rsp_valid && (rsp_data.retry_cmd == RETRY_NONE || rsp_data.retry_cmd == RETRY_STOP) |-> rsp_data.retry_secs == '0, "retry seconds without a started timer")

endmodule

bind bgp_session_fsm bsf_checker u_bsf_checker (.*);
